@@ design/sbc_pkg.sv @@
package sbc_pkg;

	localparam int unsigned DEF_WORD_BITS      = 32;
	localparam int unsigned DEF_KEY_WORDS      = 4;
	localparam int unsigned DEF_ROUND_COUNT    = 44;
	localparam int unsigned DEF_SEQUENCE_INDEX = 3;

	localparam int unsigned BLOCK_BITS     = 64;
	localparam int unsigned KEY_REG_BITS   = 64;
	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam int unsigned SEQ_LEN        = 62;
	localparam int unsigned SEQ_COUNT      = 5;
	localparam int unsigned ROUND_CONST    = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_HIGH = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_LOW  = CFG_INDEX_BITS'(1);

	// element 0 of each sequence is the leftmost digit
	localparam logic [0:SEQ_LEN-1] ZSEQ [SEQ_COUNT] = '{
		62'b1111101000100101011000011100110_1111101000100101011000011100110,
		62'b1000111011111001001100001011010_1000111011111001001100001011010,
		62'b1010111101110000001101001001100_0101000010001111110010110110011,
		62'b1101101110101100011001011110000_0010010001010011100110100001111,
		62'b1101000111100110101101100010000_0010111000011001010010011101111
	};

	typedef struct packed {
		logic load_block;
		logic load_keys;
		logic exp_step;
		logic rd_en;
		logic round_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic key_write;
		logic out_free;
	} sts_t;

endpackage

@@ design/sbc_datapath.sv @@
module sbc_datapath #(
	parameter int unsigned WORD_BITS      = sbc_pkg::DEF_WORD_BITS,
	parameter int unsigned KEY_WORDS      = sbc_pkg::DEF_KEY_WORDS,
	parameter int unsigned ROUND_COUNT    = sbc_pkg::DEF_ROUND_COUNT,
	parameter int unsigned SEQUENCE_INDEX = sbc_pkg::DEF_SEQUENCE_INDEX,
	localparam int unsigned RI_BITS       = $clog2(ROUND_COUNT)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sbc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [sbc_pkg::KEY_REG_BITS-1:0]    cfg_data,
	input  logic                                opcode,
	input  logic [sbc_pkg::BLOCK_BITS-1:0]      data_in,
	output logic [sbc_pkg::BLOCK_BITS-1:0]      data_out,
	output logic                                out_valid,
	input  logic                                out_stall,
	input  sbc_pkg::cmd_t                       cmd,
	input  logic [RI_BITS-1:0]                  idx,
	output sbc_pkg::sts_t                       sts
);
	import sbc_pkg::*;

	localparam int unsigned W        = WORD_BITS;
	localparam int unsigned KV_BITS  = KEY_WORDS * WORD_BITS;
	localparam int unsigned K3       = (KEY_WORDS == 4) ? 1 : 0;
	localparam int unsigned SEQ_SEL  = (SEQUENCE_INDEX > 4) ? 4 : SEQUENCE_INDEX;
	localparam int unsigned Z_BITS   = $clog2(SEQ_LEN);

	logic [KEY_REG_BITS-1:0] key_high_q;
	logic [KEY_REG_BITS-1:0] key_low_q;
	logic [KV_BITS-1:0]      key_vec;
	logic [W-1:0]            win_q [KEY_WORDS];
	logic [W-1:0]            t1;
	logic [W-1:0]            t2;
	logic [W-1:0]            gen;
	logic [RI_BITS:0]        idx_w;
	logic [RI_BITS:0]        z_full;
	logic [Z_BITS-1:0]       z_idx;
	logic                    zbit;
	logic [W-1:0]            rk_mem [ROUND_COUNT];
	logic [W-1:0]            rk_q;
	logic [RI_BITS-1:0]      raddr;
	logic [2*W-1:0]          blk_ext;
	logic [W-1:0]            x_q;
	logic [W-1:0]            y_q;
	logic                    dec_q;
	logic [2*W-1:0]          res;
	logic [BLOCK_BITS-1:0]   data_out_q;
	logic                    out_valid_q;

	function automatic logic [W-1:0] rotl(input logic [W-1:0] v, input int unsigned n);
		return (v << n) | (v >> (W - n));
	endfunction

	function automatic logic [W-1:0] rotr(input logic [W-1:0] v, input int unsigned n);
		return (v >> n) | (v << (W - n));
	endfunction

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_KEY_HIGH) begin
				key_high_q <= cfg_data;
			end
			if (cfg_index == REG_KEY_LOW) begin
				key_low_q <= cfg_data;
			end
		end
	end

	assign sts.key_write = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

	// key words past bit 127 read as zero
	assign key_vec = KV_BITS'({key_high_q, key_low_q});

	// next schedule word from the window of the last KEY_WORDS words
	always_comb begin
		t1 = rotr(win_q[KEY_WORDS-1], 3);
		if (KEY_WORDS == 4) begin
			t1 = t1 ^ win_q[K3];
		end
		t2     = t1 ^ rotr(t1, 1);
		idx_w  = {1'b0, idx};
		z_full = (idx_w >= (RI_BITS+1)'(SEQ_LEN)) ? idx_w - (RI_BITS+1)'(SEQ_LEN) : idx_w;
		z_idx  = Z_BITS'(z_full);
		zbit   = ZSEQ[SEQ_SEL][z_idx];
		gen    = ~win_q[0] ^ t2 ^ W'(zbit) ^ W'(ROUND_CONST);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_keys) begin
			for (int k = 0; k < KEY_WORDS; k++) begin
				win_q[k] <= key_vec[k*W +: W];
			end
		end else if (cmd.exp_step) begin
			for (int k = 0; k < KEY_WORDS - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[KEY_WORDS-1] <= gen;
		end
	end

	// round key store, at most one write and one read a cycle
	assign raddr = dec_q ? RI_BITS'(ROUND_COUNT - 1) - idx : idx;

	always_ff @(posedge clk) begin
		if (cmd.exp_step) begin
			rk_mem[idx] <= win_q[0];
		end
		if (cmd.rd_en) begin
			rk_q <= rk_mem[raddr];
		end
	end

	// block state and the round function
	assign blk_ext = (2*W)'(data_in);

	always_ff @(posedge clk) begin
		if (cmd.load_block) begin
			dec_q <= opcode;
			if (opcode) begin
				x_q <= blk_ext[W-1:0];
				y_q <= blk_ext[2*W-1:W];
			end else begin
				x_q <= blk_ext[2*W-1:W];
				y_q <= blk_ext[W-1:0];
			end
		end else if (cmd.round_step) begin
			x_q <= y_q ^ ((rotl(x_q, 1) & rotl(x_q, 8)) ^ rotl(x_q, 2)) ^ rk_q;
			y_q <= x_q;
		end
	end

	assign res = dec_q ? {y_q, x_q} : {x_q, y_q};

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			data_out_q <= BLOCK_BITS'(res);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign data_out     = data_out_q;

endmodule

@@ design/sbc_ctrl.sv @@
module sbc_ctrl #(
	parameter int unsigned ROUND_COUNT = sbc_pkg::DEF_ROUND_COUNT,
	localparam int unsigned RI_BITS    = $clog2(ROUND_COUNT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sbc_pkg::sts_t       sts,
	output sbc_pkg::cmd_t       cmd,
	output logic [RI_BITS-1:0]  idx
);
	import sbc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXPAND = 5'b00010,
		S_PRIME  = 5'b00100,
		S_ROUND  = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	localparam logic [RI_BITS-1:0] LAST = RI_BITS'(ROUND_COUNT - 1);

	state_t             state_q;
	state_t             state_d;
	logic [RI_BITS-1:0] cnt_q;
	logic [RI_BITS-1:0] cnt_d;
	logic               sched_ready_q;
	logic               accept;
	logic               exp_last;

	assign accept   = in_valid && !in_stall;
	assign exp_last = (state_q == S_EXPAND) && (cnt_q == LAST);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		idx      = cnt_q;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_block = 1'b1;
					cnt_d          = '0;
					if (sched_ready_q) begin
						state_d = S_PRIME;
					end else begin
						cmd.load_keys = 1'b1;
						state_d       = S_EXPAND;
					end
				end
			end
			S_EXPAND: begin
				cmd.exp_step = 1'b1;
				if (cnt_q == LAST) begin
					cnt_d   = '0;
					state_d = S_PRIME;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_PRIME: begin
				// first round key read
				cmd.rd_en = 1'b1;
				state_d   = S_ROUND;
			end
			S_ROUND: begin
				cmd.round_step = 1'b1;
				idx            = cnt_q + 1'b1;
				cmd.rd_en      = (cnt_q != LAST);
				if (cnt_q == LAST) begin
					state_d = S_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			sched_ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (sts.key_write) begin
				sched_ready_q <= 1'b0;
			end else if (exp_last) begin
				sched_ready_q <= 1'b1;
			end
		end
	end

	a_key_write_clears: assert property (@(posedge clk) disable iff (!arst_n)
		sts.key_write |=> !sched_ready_q)
		else $error("schedule still marked ready after a key write");

	a_round_after_prime: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && $past(state_q) != S_ROUND) |-> $past(state_q) == S_PRIME)
		else $error("rounds started without a key read");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LAST)
		else $error("round counter out of range");

	a_expand_from_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXPAND && $past(state_q) == S_IDLE) |-> cnt_q == '0)
		else $error("key expansion did not start at entry zero");

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXPAND || state_q == S_PRIME))
		else $error("accepted transaction did not start work");

endmodule

@@ design/simon_block_cipher_top.sv @@
// simon block cipher core, 64-bit blocks, key held in two 64-bit registers
// config: write key_high (index 0) and key_low (index 1) with cfg_we while
//   the core is idle; a write to any other index is ignored
// input channel: in_valid/in_stall carry opcode (0 encrypt, 1 decrypt) and
//   data_in; in_stall is low only while the core is idle
// output channel: out_valid/out_stall carry data_out from an output register,
//   so a new block is taken while a finished result still waits
// timing: one round per cycle on a single round unit, fed by the one read
//   port of the round key store; after accept a block reads its first round
//   key, runs its rounds and then loads the output register, and only then
//   is the next block accepted
// the first block after reset or after a key write first expands the key
//   into the round key store, one store entry per cycle
// reset: state machine idle, key registers zero, schedule marked stale,
//   output empty; the round key store itself is not cleared
// a stalled receiver holds data_out; a finished block waits in the core
//   until the output register frees, holding off new transactions
module simon_block_cipher_top #(
	parameter int unsigned WORD_BITS      = sbc_pkg::DEF_WORD_BITS,
	parameter int unsigned KEY_WORDS      = sbc_pkg::DEF_KEY_WORDS,
	parameter int unsigned ROUND_COUNT    = sbc_pkg::DEF_ROUND_COUNT,
	parameter int unsigned SEQUENCE_INDEX = sbc_pkg::DEF_SEQUENCE_INDEX
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sbc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [sbc_pkg::KEY_REG_BITS-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                opcode,
	input  logic [sbc_pkg::BLOCK_BITS-1:0]      data_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sbc_pkg::BLOCK_BITS-1:0]      data_out
);
	import sbc_pkg::*;

	localparam int unsigned RI_BITS = $clog2(ROUND_COUNT);

	cmd_t               cmd;
	sts_t               sts;
	logic [RI_BITS-1:0] idx;

	sbc_ctrl #(
		.ROUND_COUNT (ROUND_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd),
		.idx      (idx)
	);

	sbc_datapath #(
		.WORD_BITS      (WORD_BITS),
		.KEY_WORDS      (KEY_WORDS),
		.ROUND_COUNT    (ROUND_COUNT),
		.SEQUENCE_INDEX (SEQUENCE_INDEX)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.opcode    (opcode),
		.data_in   (data_in),
		.data_out  (data_out),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.idx       (idx),
		.sts       (sts)
	);

endmodule
